[src/rgbhsv_pkg.sv]
// Shared widths and types for the RGB to HSV pixel converter.
// No dependencies; imported by the core and its checker.
package rgbhsv_pkg;

   localparam int PIX_W      = 8;               // channel and result width
   localparam int QUO_W      = 8;               // quotient bits, one per divide stage
   localparam int SAT_DEND_W = 2 * PIX_W;       // 255*M fits in 16 bits
   localparam int HUE_NUM_W  = 11;              // hue numerator, 0..1529
   localparam int HUE_DIV_W  = 11;              // 6*c, up to 1530
   localparam int HUE_DEND_W = HUE_NUM_W + PIX_W; // 255*num

   typedef enum logic [1:0] {
      SECT_RED,
      SECT_GREEN,
      SECT_BLUE
   } sector_type;

endpackage

[src/rgb_to_hsv_pixel_core.sv]
// RGB to HSV pixel converter core: max/min, sector select, and two
// pipelined restoring dividers. Depends on rgbhsv_pkg.
//
// Takes one 8-bit RGB pixel per clock and returns 8-bit hue, saturation and
// value with exact truncating integer division. The pipeline has one
// stage for max/min, one for chroma and hue numerator, one for the x255
// scaling, and eight restoring divide stages (one quotient bit each) that
// run the saturation and hue divisions side by side. The whole pipeline
// moves when the output register is empty or being taken, so throughput is
// one pixel per clock whenever rsp_ready is held high; a stall freezes all
// stages in place.
module rgb_to_hsv_pixel_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [rgbhsv_pkg::PIX_W-1:0]  req_red,
   input  logic [rgbhsv_pkg::PIX_W-1:0]  req_green,
   input  logic [rgbhsv_pkg::PIX_W-1:0]  req_blue,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [rgbhsv_pkg::PIX_W-1:0]  rsp_hue,
   output logic [rgbhsv_pkg::PIX_W-1:0]  rsp_saturation,
   output logic [rgbhsv_pkg::PIX_W-1:0]  rsp_value
);
   import rgbhsv_pkg::*;

   logic advance;

   // stage A: max, min, sector
   logic             a_valid_ff;
   logic [PIX_W-1:0] a_red_ff, a_green_ff, a_blue_ff, a_max_ff, a_min_ff;
   sector_type       a_sect_ff;
   logic [PIX_W-1:0] a_max_in, a_min_in;
   sector_type       a_sect_in;

   // stage B: chroma, hue numerator
   logic                 b_valid_ff;
   logic [PIX_W-1:0]     b_max_ff, b_chroma_ff;
   logic [HUE_NUM_W-1:0] b_num_ff;
   logic [PIX_W-1:0]     b_chroma_in;
   logic [HUE_NUM_W-1:0] b_num_in;
   logic [HUE_DIV_W-1:0] b_six_c;
   logic signed [HUE_NUM_W:0] num_s;

   // divide pipeline, index 0 is the scaling stage
   logic                  vld_ff      [0:QUO_W];
   logic [PIX_W-1:0]      val_ff      [0:QUO_W];
   logic                  sat_zero_ff [0:QUO_W];
   logic                  hue_zero_ff [0:QUO_W];
   logic [SAT_DEND_W-1:0] srem_ff     [0:QUO_W];
   logic [PIX_W-1:0]      sdiv_ff     [0:QUO_W];
   logic [QUO_W-1:0]      squo_ff     [0:QUO_W];
   logic [HUE_DEND_W-1:0] hrem_ff     [0:QUO_W];
   logic [HUE_DIV_W-1:0]  hdiv_ff     [0:QUO_W];
   logic [QUO_W-1:0]      hquo_ff     [0:QUO_W];

   assign advance   = ~vld_ff[QUO_W] | rsp_ready;
   assign req_ready = advance;

   // ---------------- stage A ----------------
   always_comb begin
      a_max_in = req_red;
      a_min_in = req_red;
      if (req_green > a_max_in) a_max_in = req_green;
      if (req_blue  > a_max_in) a_max_in = req_blue;
      if (req_green < a_min_in) a_min_in = req_green;
      if (req_blue  < a_min_in) a_min_in = req_blue;
      // ties: blue over green over red
      if (req_blue == a_max_in)       a_sect_in = SECT_BLUE;
      else if (req_green == a_max_in) a_sect_in = SECT_GREEN;
      else                            a_sect_in = SECT_RED;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= req_valid;
      end
      if (advance) begin
         a_red_ff   <= req_red;
         a_green_ff <= req_green;
         a_blue_ff  <= req_blue;
         a_max_ff   <= a_max_in;
         a_min_ff   <= a_min_in;
         a_sect_ff  <= a_sect_in;
      end
   end

   // ---------------- stage B ----------------
   always_comb begin
      b_chroma_in = a_max_ff - a_min_ff;
      b_six_c     = {1'b0, b_chroma_in, 2'b00} + {2'b00, b_chroma_in, 1'b0};
      unique case (a_sect_ff)
         SECT_BLUE: begin
            num_s = $signed({2'b00, b_chroma_in, 2'b00})
                  + $signed({4'b0000, a_red_ff}) - $signed({4'b0000, a_green_ff});
         end
         SECT_GREEN: begin
            num_s = $signed({3'b000, b_chroma_in, 1'b0})
                  + $signed({4'b0000, a_blue_ff}) - $signed({4'b0000, a_red_ff});
         end
         default: begin
            num_s = $signed({4'b0000, a_green_ff}) - $signed({4'b0000, a_blue_ff});
            // red sector wraps a negative numerator by one full turn
            if (num_s < 0) num_s = num_s + $signed({1'b0, b_six_c});
         end
      endcase
      b_num_in = num_s[HUE_NUM_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (advance) begin
         b_valid_ff <= a_valid_ff;
      end
      if (advance) begin
         b_max_ff    <= a_max_ff;
         b_chroma_ff <= b_chroma_in;
         b_num_ff    <= b_num_in;
      end
   end

   // ---------------- scaling stage ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (advance) begin
         vld_ff[0] <= b_valid_ff;
      end
      if (advance) begin
         val_ff[0]      <= b_max_ff;
         sat_zero_ff[0] <= (b_max_ff == '0);
         hue_zero_ff[0] <= (b_chroma_ff == '0);
         srem_ff[0]     <= {b_chroma_ff, {PIX_W{1'b0}}} - {{PIX_W{1'b0}}, b_chroma_ff};
         sdiv_ff[0]     <= b_max_ff;
         squo_ff[0]     <= '0;
         hrem_ff[0]     <= {b_num_ff, {PIX_W{1'b0}}} - {{PIX_W{1'b0}}, b_num_ff};
         hdiv_ff[0]     <= {1'b0, b_chroma_ff, 2'b00} + {2'b00, b_chroma_ff, 1'b0};
         hquo_ff[0]     <= '0;
      end
   end

   // ---------------- restoring divide, one quotient bit per stage ----------------
   for (genvar k = 1; k <= QUO_W; k++) begin : g_div
      localparam int SH = QUO_W - k;
      logic [SAT_DEND_W-1:0] s_shift;
      logic [HUE_DEND_W-1:0] h_shift;
      logic                  s_ge, h_ge;

      assign s_shift = SAT_DEND_W'(sdiv_ff[k-1]) << SH;
      assign h_shift = HUE_DEND_W'(hdiv_ff[k-1]) << SH;
      assign s_ge    = srem_ff[k-1] >= s_shift;
      assign h_ge    = hrem_ff[k-1] >= h_shift;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (advance) begin
            vld_ff[k] <= vld_ff[k-1];
         end
         if (advance) begin
            val_ff[k]      <= val_ff[k-1];
            sat_zero_ff[k] <= sat_zero_ff[k-1];
            hue_zero_ff[k] <= hue_zero_ff[k-1];
            sdiv_ff[k]     <= sdiv_ff[k-1];
            hdiv_ff[k]     <= hdiv_ff[k-1];
            srem_ff[k]     <= s_ge ? srem_ff[k-1] - s_shift : srem_ff[k-1];
            hrem_ff[k]     <= h_ge ? hrem_ff[k-1] - h_shift : hrem_ff[k-1];
            squo_ff[k]     <= {squo_ff[k-1][QUO_W-2:0], s_ge};
            hquo_ff[k]     <= {hquo_ff[k-1][QUO_W-2:0], h_ge};
         end
      end
   end

   // black pixel: zero divisor, grey pixel: no hue
   assign rsp_valid      = vld_ff[QUO_W];
   assign rsp_value      = val_ff[QUO_W];
   assign rsp_saturation = sat_zero_ff[QUO_W] ? '0 : squo_ff[QUO_W];
   assign rsp_hue        = hue_zero_ff[QUO_W] ? '0 : hquo_ff[QUO_W];

endmodule

[src/rgbhsv_chk.sv]
// Port-level checker for the RGB to HSV pixel core, bound to the top level.
// Depends on rgbhsv_pkg and rgb_to_hsv_pixel_core.
module rgbhsv_chk (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic [rgbhsv_pkg::PIX_W-1:0]  req_red,
   input logic [rgbhsv_pkg::PIX_W-1:0]  req_green,
   input logic [rgbhsv_pkg::PIX_W-1:0]  req_blue,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [rgbhsv_pkg::PIX_W-1:0]  rsp_hue,
   input logic [rgbhsv_pkg::PIX_W-1:0]  rsp_saturation,
   input logic [rgbhsv_pkg::PIX_W-1:0]  rsp_value
);
   import rgbhsv_pkg::*;

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hue)
         && $stable(rsp_saturation) && $stable(rsp_value))
      else $error("result word changed while stalled");

   // an empty output stage never blocks the input
   a_no_idle_block: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input blocked with empty output");

   // black pixel gives zero saturation and hue
   a_black: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_value == '0 |-> rsp_saturation == '0 && rsp_hue == '0)
      else $error("black pixel with nonzero hue or saturation");

   // zero saturation means zero chroma, hence no hue
   a_grey: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturation == '0 |-> rsp_hue == '0)
      else $error("grey pixel with nonzero hue");

   // numerator stays below 6c, so hue tops out at 254
   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_hue != {PIX_W{1'b1}})
      else $error("hue out of range");

endmodule

bind rgb_to_hsv_pixel_core rgbhsv_chk u_rgbhsv_chk (.*);

[sim/tb_rgb_to_hsv_pixel_core.sv]
`timescale 1ns / 100ps
// Self-checking testbench for rgb_to_hsv_pixel_core: random and corner pixels,
// predicted hue/saturation/value checked in order. Depends on rgbhsv_pkg and the core.
module tb_rgb_to_hsv_pixel_core;
   import rgbhsv_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int ITEMS_PER_RUN = 450;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 24;

   typedef struct packed {
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
      logic [PIX_W-1:0] hue;
      logic [PIX_W-1:0] saturation;
      logic [PIX_W-1:0] value;
   } hsv_entry_type;

   // Holds the HSV words still owed by the core, oldest first.
   class hsv_tracker_type;
      hsv_entry_type owed_hsv[$];
      int            mismatches;

      function hsv_entry_type convert(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g,
                                      logic [PIX_W-1:0] b);
         hsv_entry_type e;
         int            ri, gi, bi, top, bottom, chroma, num;
         sector_type    sect;
         ri = int'(r);
         gi = int'(g);
         bi = int'(b);
         top = ri;
         bottom = ri;
         if (gi > top) top = gi;
         if (bi > top) top = bi;
         if (gi < bottom) bottom = gi;
         if (bi < bottom) bottom = bi;
         chroma = top - bottom;
         e.red = r;
         e.green = g;
         e.blue = b;
         e.value = PIX_W'(top);
         e.saturation = (top == 0) ? '0 : PIX_W'((255 * chroma) / top);
         e.hue = '0;
         if (chroma != 0) begin
            // blue wins ties, then green
            if (top == bi) sect = SECT_BLUE;
            else if (top == gi) sect = SECT_GREEN;
            else sect = SECT_RED;
            case (sect)
               SECT_BLUE: num = 4 * chroma + (ri - gi);
               SECT_GREEN: num = 2 * chroma + (bi - ri);
               default: num = gi - bi;
            endcase
            if (num < 0) num += 6 * chroma;
            e.hue = PIX_W'((255 * num) / (6 * chroma));
         end
         return e;
      endfunction

      function void note_pixel(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g,
                               logic [PIX_W-1:0] b);
         owed_hsv.push_back(convert(r, g, b));
      endfunction

      function void check_hsv(logic [PIX_W-1:0] h, logic [PIX_W-1:0] s,
                              logic [PIX_W-1:0] v);
         hsv_entry_type e;
         string         bad;
         if (owed_hsv.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected word h/s/v %0d/%0d/%0d at %0t", h, s, v, $realtime);
            return;
         end
         e = owed_hsv.pop_front();
         bad = "";
         if (h !== e.hue) bad = {bad, " hue"};
         if (s !== e.saturation) bad = {bad, " saturation"};
         if (v !== e.value) bad = {bad, " value"};
         if (bad != "") begin
            mismatches++;
            if (mismatches <= 10)
               $display({"mismatch on%s rgb=(%0d,%0d,%0d): ",
                         "exp h/s/v %0d/%0d/%0d, got %0d/%0d/%0d"},
                        bad, e.red, e.green, e.blue, e.hue, e.saturation, e.value,
                        h, s, v);
         end
      endfunction

      function int outstanding();
         return owed_hsv.size();
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   logic [PIX_W-1:0] req_red;
   logic [PIX_W-1:0] req_green;
   logic [PIX_W-1:0] req_blue;
   logic             rsp_valid;
   logic             rsp_ready;
   logic [PIX_W-1:0] rsp_hue;
   logic [PIX_W-1:0] rsp_saturation;
   logic [PIX_W-1:0] rsp_value;

   hsv_tracker_type tracker;
   int              sender_idle_pct;
   int              receiver_stall_pct;
   bit              hold_request;
   int              hold_left;
   int              cycle_count;

   rgb_to_hsv_pixel_core DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_red        (req_red),
      .req_green      (req_green),
      .req_blue       (req_blue),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_hue        (rsp_hue),
      .rsp_saturation (rsp_saturation),
      .rsp_value      (rsp_value)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("== FAIL ==");
      $finish;
   end

   // hold request is raised at a falling edge, latched here at the rising one
   always @(posedge clock) begin
      if (hold_request) begin
         hold_left = HOLD_CYCLES;
         hold_request = 1'b0;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left = hold_left - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) tracker.note_pixel(req_red, req_green, req_blue);
         if (rsp_valid && rsp_ready) tracker.check_hsv(rsp_hue, rsp_saturation, rsp_value);
      end
   end

   // Called and returns at a falling edge; valid stays up for a back-to-back word.
   task automatic send_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                             input logic [PIX_W-1:0] b);
      int gap;
      gap = 0;
      while (gap < 20 && $urandom_range(99) < sender_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_red <= r;
      req_green <= g;
      req_blue <= b;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic random_rgb(output logic [PIX_W-1:0] r, output logic [PIX_W-1:0] g,
                             output logic [PIX_W-1:0] b);
      int               kind;
      int               base;
      logic [PIX_W-1:0] v;
      kind = $urandom_range(99);
      r = PIX_W'($urandom);
      g = PIX_W'($urandom);
      b = PIX_W'($urandom);
      v = PIX_W'($urandom);
      if (kind >= 60 && kind < 75) begin
         // two channels tied, or all three equal
         case ($urandom_range(3))
            0: begin r = v; g = v; end
            1: begin g = v; b = v; end
            2: begin r = v; b = v; end
            default: begin r = v; g = v; b = v; end
         endcase
      end else if (kind >= 75 && kind < 85) begin
         r = PIX_W'($urandom_range(3));
         g = PIX_W'($urandom_range(3));
         b = PIX_W'($urandom_range(3));
      end else if (kind >= 85 && kind < 93) begin
         r = $urandom_range(1) ? 8'd255 : 8'd0;
         g = $urandom_range(1) ? 8'd255 : 8'd0;
         b = $urandom_range(1) ? 8'd255 : 8'd0;
      end else if (kind >= 93) begin
         // near grey: chroma of at most 2 around a random base level
         base = int'($urandom_range(254, 1));
         r = PIX_W'(base + int'($urandom_range(2)) - 1);
         g = PIX_W'(base + int'($urandom_range(2)) - 1);
         b = PIX_W'(base + int'($urandom_range(2)) - 1);
      end
   endtask

   task automatic random_run(input int count, input bit with_hold);
      logic [PIX_W-1:0] r, g, b;
      for (int i = 0; i < count; i++) begin
         if (with_hold && i == count / 3) hold_request = 1'b1;
         random_rgb(r, g, b);
         send_pixel(r, g, b);
      end
   endtask

   // Sender pauses until every owed word is back, then idling is changed.
   task automatic drain_then_set(input int send_pct, input int recv_pct);
      req_valid <= 1'b0;
      while (tracker.outstanding() != 0) @(negedge clock);
      @(posedge clock);
      sender_idle_pct = send_pct;
      receiver_stall_pct = recv_pct;
      @(negedge clock);
   endtask

   initial begin
      tracker = new;
      reset = 1'b1;
      req_valid = 1'b0;
      req_red = '0;
      req_green = '0;
      req_blue = '0;
      rsp_ready = 1'b0;
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      hold_request = 1'b0;
      hold_left = 0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // black, white, grey, primaries, secondaries
      send_pixel(8'd0, 8'd0, 8'd0);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd128, 8'd128, 8'd128);
      send_pixel(8'd1, 8'd1, 8'd1);
      send_pixel(8'd255, 8'd0, 8'd0);
      send_pixel(8'd0, 8'd255, 8'd0);
      send_pixel(8'd0, 8'd0, 8'd255);
      send_pixel(8'd255, 8'd255, 8'd0);
      send_pixel(8'd0, 8'd255, 8'd255);
      send_pixel(8'd255, 8'd0, 8'd255);
      // ties at the max
      send_pixel(8'd200, 8'd200, 8'd17);
      send_pixel(8'd9, 8'd200, 8'd200);
      send_pixel(8'd200, 8'd31, 8'd200);
      // red sector with blue over green: numerator wraps
      send_pixel(8'd255, 8'd0, 8'd1);
      send_pixel(8'd200, 8'd10, 8'd50);
      send_pixel(8'd255, 8'd0, 8'd254);
      // smallest chroma and smallest max
      send_pixel(8'd1, 8'd0, 8'd0);
      send_pixel(8'd0, 8'd0, 8'd1);
      send_pixel(8'd128, 8'd127, 8'd127);
      send_pixel(8'd254, 8'd255, 8'd254);
      send_pixel(8'd0, 8'd255, 8'd254);
      send_pixel(8'd170, 8'd85, 8'd0);

      drain_then_set(0, 0);
      random_run(ITEMS_PER_RUN, 1'b1);
      drain_then_set(55, 0);
      random_run(ITEMS_PER_RUN, 1'b0);
      drain_then_set(0, 55);
      random_run(ITEMS_PER_RUN, 1'b0);
      drain_then_set(36, 36);
      random_run(ITEMS_PER_RUN, 1'b0);
      drain_then_set(0, 0);
      repeat (SETTLE_CYCLES) @(negedge clock);

      if (tracker.outstanding() != 0) begin
         tracker.mismatches++;
         $display("%0d words never returned", tracker.outstanding());
      end
      if (tracker.mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

[rgb_to_hsv_pixel_core.f]
src/rgbhsv_pkg.sv
src/rgb_to_hsv_pixel_core.sv
src/rgbhsv_chk.sv
sim/tb_rgb_to_hsv_pixel_core.sv
